// ===== rtl/core/segment_segment_intersection_top_defines.svh =====
// assertion macros for the segment intersection core
// expects clk and arst_n in the scope of each use
`ifndef SEGMENT_SEGMENT_INTERSECTION_TOP_DEFINES_SVH
`define SEGMENT_SEGMENT_INTERSECTION_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SSI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SSI_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ssi_pkg.sv =====
// shared types and constants for the segment intersection core
// no dependencies
package ssi_pkg;

	// default coordinate width
	localparam int unsigned COORD_WIDTH_DEF = 16;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_SEG_AX = 2'd0,
		CFG_SEG_AY = 2'd1,
		CFG_SEG_BX = 2'd2,
		CFG_SEG_BY = 2'd3
	} cfg_reg_t;

	// bounding box flags: endpoint lies inside the other segment's box
	typedef struct packed {
		logic p_in_ab;
		logic q_in_ab;
		logic a_in_pq;
		logic b_in_pq;
	} bbox_t;

endpackage

// ===== rtl/core/segment_segment_intersection_top.sv =====
// segment intersection core: query segment p-q against obstacle segment a-b
// depends on ssi_pkg and segment_segment_intersection_top_defines.svh
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------------
//  cfg     | cfg_valid / cfg_ready      | cfg_index, cfg_data (seg_ax..seg_by)
//  in      | in_valid / in_ready        | query_ax, query_ay, query_bx, query_by
//  out     | out_valid / out_ready      | hit
//
// four register stages: differences, products, cross products, compare
// one word accepted per cycle while in_ready is high; an accepted word passes s1, s2, s3
// and s4 in turn, and out_valid is the s4 valid bit
// each stage fills a bubble on its own, so the input side keeps moving while a
// result waits at the output register until the output side stalls all four stages
// reset clears the stage valid bits and the obstacle segment to all zero
// the configuration port is always ready; write it only while the pipe is empty
module segment_segment_intersection_top #(
	parameter int unsigned COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  ssi_pkg::cfg_reg_t             cfg_index,
	input  logic signed [COORD_WIDTH-1:0] cfg_data,
	// query segment
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] query_ax,
	input  logic signed [COORD_WIDTH-1:0] query_ay,
	input  logic signed [COORD_WIDTH-1:0] query_bx,
	input  logic signed [COORD_WIDTH-1:0] query_by,
	// result
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit
);
	import ssi_pkg::*;

	`include "segment_segment_intersection_top_defines.svh"

	// a difference of two coordinates needs one more bit
	localparam int unsigned DW = COORD_WIDTH + 1;
	// product of two differences
	localparam int unsigned PW = 2 * DW;
	// difference of two products
	localparam int unsigned CW = PW + 1;

	function automatic logic within_f(
		input logic signed [COORD_WIDTH-1:0] v,
		input logic signed [COORD_WIDTH-1:0] e0,
		input logic signed [COORD_WIDTH-1:0] e1
	);
		return ((v >= e0) && (v <= e1)) || ((v >= e1) && (v <= e0));
	endfunction

	function automatic logic in_unit_f(
		input logic signed [CW-1:0] num,
		input logic signed [CW-1:0] den
	);
		logic pos;
		pos = (den > 0);
		return pos ? ((num >= 0) && (num <= den)) : ((num <= 0) && (num >= den));
	endfunction

	// obstacle segment registers
	logic signed [COORD_WIDTH-1:0] seg_ax_q, seg_ay_q, seg_bx_q, seg_by_q;

	// stage valid bits and per-stage ready
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	// stage 1: coordinate differences and box flags
	logic signed [DW-1:0] dabx_s1, daby_s1;   // a - b
	logic signed [DW-1:0] dpqx_s1, dpqy_s1;   // p - q
	logic signed [DW-1:0] dapx_s1, dapy_s1;   // a - p
	logic signed [DW-1:0] daqx_s1, daqy_s1;   // a - q
	logic signed [DW-1:0] dbpx_s1, dbpy_s1;   // b - p
	bbox_t                box_s1;
	bbox_t                box_d;

	// stage 2: products
	logic signed [PW-1:0] den0_s2, den1_s2;
	logic signed [PW-1:0] tn0_s2, tn1_s2;
	logic signed [PW-1:0] un0_s2, un1_s2;
	logic signed [PW-1:0] cq0_s2, cq1_s2;
	logic signed [PW-1:0] cb0_s2, cb1_s2;
	bbox_t                box_s2;

	// stage 3: cross products
	logic signed [CW-1:0] den_s3, tn_s3, un_s3, cq_s3, cb_s3;
	bbox_t                box_s3;

	// stage 4: result register
	logic                 hit_s4;
	logic                 hit_d;
	logic                 parallel_hit;
	logic                 cross_hit;

	//--------------------------------------------------------------------------
	// configuration
	//--------------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_ax_q <= '0;
			seg_ay_q <= '0;
			seg_bx_q <= '0;
			seg_by_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SEG_AX: seg_ax_q <= cfg_data;
				CFG_SEG_AY: seg_ay_q <= cfg_data;
				CFG_SEG_BX: seg_bx_q <= cfg_data;
				CFG_SEG_BY: seg_by_q <= cfg_data;
				default: ;
			endcase
		end
	end

	//--------------------------------------------------------------------------
	// pipeline flow control: a stage takes a word when empty or when it drains
	//--------------------------------------------------------------------------
	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	//--------------------------------------------------------------------------
	// stage 1: differences, inclusive bounding box tests
	//--------------------------------------------------------------------------
	always_comb begin
		box_d.p_in_ab = within_f(query_ax, seg_ax_q, seg_bx_q)
			&& within_f(query_ay, seg_ay_q, seg_by_q);
		box_d.q_in_ab = within_f(query_bx, seg_ax_q, seg_bx_q)
			&& within_f(query_by, seg_ay_q, seg_by_q);
		box_d.a_in_pq = within_f(seg_ax_q, query_ax, query_bx)
			&& within_f(seg_ay_q, query_ay, query_by);
		box_d.b_in_pq = within_f(seg_bx_q, query_ax, query_bx)
			&& within_f(seg_by_q, query_ay, query_by);
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			dabx_s1 <= DW'(seg_ax_q) - DW'(seg_bx_q);
			daby_s1 <= DW'(seg_ay_q) - DW'(seg_by_q);
			dpqx_s1 <= DW'(query_ax) - DW'(query_bx);
			dpqy_s1 <= DW'(query_ay) - DW'(query_by);
			dapx_s1 <= DW'(seg_ax_q) - DW'(query_ax);
			dapy_s1 <= DW'(seg_ay_q) - DW'(query_ay);
			daqx_s1 <= DW'(seg_ax_q) - DW'(query_bx);
			daqy_s1 <= DW'(seg_ay_q) - DW'(query_by);
			dbpx_s1 <= DW'(seg_bx_q) - DW'(query_ax);
			dbpy_s1 <= DW'(seg_by_q) - DW'(query_ay);
			box_s1  <= box_d;
		end
	end

	//--------------------------------------------------------------------------
	// stage 2: the ten products
	//--------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			// den = cross(a - b, p - q)
			den0_s2 <= PW'(dabx_s1) * PW'(dpqy_s1);
			den1_s2 <= PW'(daby_s1) * PW'(dpqx_s1);
			// tn = cross(a - p, p - q), also the a-on-pq collinearity term
			tn0_s2  <= PW'(dapx_s1) * PW'(dpqy_s1);
			tn1_s2  <= PW'(dapy_s1) * PW'(dpqx_s1);
			// un = cross(b - a, a - p), zero exactly when p is on line ab
			un0_s2  <= PW'(daby_s1) * PW'(dapx_s1);
			un1_s2  <= PW'(dabx_s1) * PW'(dapy_s1);
			// q on line ab
			cq0_s2  <= PW'(dabx_s1) * PW'(daqy_s1);
			cq1_s2  <= PW'(daby_s1) * PW'(daqx_s1);
			// b on line pq
			cb0_s2  <= PW'(dpqy_s1) * PW'(dbpx_s1);
			cb1_s2  <= PW'(dpqx_s1) * PW'(dbpy_s1);
			box_s2  <= box_s1;
		end
	end

	//--------------------------------------------------------------------------
	// stage 3: cross products
	//--------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			den_s3 <= CW'(den0_s2) - CW'(den1_s2);
			tn_s3  <= CW'(tn0_s2) - CW'(tn1_s2);
			un_s3  <= CW'(un0_s2) - CW'(un1_s2);
			cq_s3  <= CW'(cq0_s2) - CW'(cq1_s2);
			cb_s3  <= CW'(cb0_s2) - CW'(cb1_s2);
			box_s3 <= box_s2;
		end
	end

	//--------------------------------------------------------------------------
	// stage 4: decision
	//--------------------------------------------------------------------------
	always_comb begin
		// parallel or collinear: some endpoint sits on the other segment
		parallel_hit = ((un_s3 == '0) && box_s3.p_in_ab)
			|| ((cq_s3 == '0) && box_s3.q_in_ab)
			|| ((tn_s3 == '0) && box_s3.a_in_pq)
			|| ((cb_s3 == '0) && box_s3.b_in_pq);
		// crossing lines: both parameters in the closed unit interval
		cross_hit = in_unit_f(tn_s3, den_s3) && in_unit_f(un_s3, den_s3);
		hit_d = (den_s3 == '0) ? parallel_hit : cross_hit;
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			hit_s4 <= hit_d;
		end
	end

	assign out_valid = valid_s4;
	assign hit       = hit_s4;

	//--------------------------------------------------------------------------
	// checks
	//--------------------------------------------------------------------------
	`SSI_ASSERT_NXT(a_accept_fills_s1, in_valid && in_ready, valid_s1, "accepted word lost at s1")
	`SSI_ASSERT_NXT(a_s3_moves_to_s4, valid_s3 && ready_s4, valid_s4, "word lost between s3 and s4")
	`SSI_ASSERT_IMP(a_bubble_takes_input, !valid_s1, in_ready, "empty s1 refuses input")
	`SSI_ASSERT_NXT(a_end_touch_hits, valid_s3 && ready_s4 && (den_s3 != '0) && (tn_s3 == '0) && (un_s3 == '0), hit, "shared endpoint missed")

endmodule

// ===== tb/sv/segment_segment_intersection_top_tb.sv =====
// self-checking bench for segment_segment_intersection_top: query words against an obstacle
// depends on ssi_pkg and the rtl core; a local predictor works out every expected hit bit
// directed corner queries first, then random phases under several obstacles and idle mixes
module segment_segment_intersection_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ssi_pkg::*;

	localparam int W = COORD_WIDTH_DEF;
	localparam longint C_MIN = -(longint'(1) <<< (W - 1));
	localparam longint C_MAX = (longint'(1) <<< (W - 1)) - 1;
	localparam int RAND_PER_PHASE = 190;
	localparam int N_PHASES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef logic signed [W-1:0] coord_t;

	// one segment: first endpoint (ax, ay), second endpoint (bx, by)
	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
	} seg_t;

	logic clk;
	logic arst_n = 1'b0;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = CFG_SEG_AX;
	coord_t cfg_data = '0;

	logic in_valid = 1'b0;
	logic in_ready;
	coord_t query_ax = '0;
	coord_t query_ay = '0;
	coord_t query_bx = '0;
	coord_t query_by = '0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;

	segment_segment_intersection_top #(
		.COORD_WIDTH(W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.query_ax(query_ax),
		.query_ay(query_ay),
		.query_bx(query_bx),
		.query_by(query_by),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit)
	);

	// 4 ns period
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// bench copy of the obstacle registers, tracked from the config handshakes
	seg_t obstacle = '0;

	seg_t query_q[$];	// query words waiting to be offered
	bit hit_due_q[$];	// predicted hit bits, oldest first

	int send_idle = 0;	// percent of offer slots the sender leaves empty
	int recv_stall = 0;	// percent of cycles the receiver holds out_ready low
	bit hold_arm = 1'b0;
	int hold_left = 0;
	bit in_acc = 1'b0;	// the word on the input port was taken at the last edge

	int errors = 0;
	int n_queries = 0;
	int n_hits = 0;
	int n_flat = 0;
	int n_settings = 0;
	int stall_run = 0;
	int stall_max = 0;
	int unsigned cycle_cnt = 0;

	// ---------------------------------------------------------------- predictor

	function automatic longint cross2(longint ux, longint uy, longint vx, longint vy);
		return ux * vy - uy * vx;
	endfunction

	function automatic bit between(longint v, longint e0, longint e1);
		return (e0 < e1) ? (v >= e0 && v <= e1) : (v >= e1 && v <= e0);
	endfunction

	// point (px, py) on the closed segment (x0, y0)-(x1, y1), box edges included
	function automatic bit on_seg(longint x0, longint y0, longint x1, longint y1,
		longint px, longint py);
		if (cross2(x1 - x0, y1 - y0, px - x0, py - y0) != 0)
			return 1'b0;
		return between(px, x0, x1) && between(py, y0, y1);
	endfunction

	// num/den within [0,1] without dividing
	function automatic bit in_unit(longint num, longint den);
		if (den > 0)
			return num >= 0 && num <= den;
		return num <= 0 && num >= den;
	endfunction

	// does query p-q share a point with obstacle a-b; flat flags parallel lines
	function automatic bit touches(seg_t o, seg_t q, output bit flat);
		longint ax, ay, bx, by, px, py, qx, qy, den, tn, un;
		ax = o.ax;
		ay = o.ay;
		bx = o.bx;
		by = o.by;
		px = q.ax;
		py = q.ay;
		qx = q.bx;
		qy = q.by;
		den = cross2(ax - bx, ay - by, px - qx, py - qy);
		flat = (den == 0);
		if (flat) begin
			// parallel or collinear: any endpoint lying on the other segment
			return on_seg(ax, ay, bx, by, px, py) || on_seg(ax, ay, bx, by, qx, qy) ||
				on_seg(px, py, qx, qy, ax, ay) || on_seg(px, py, qx, qy, bx, by);
		end
		tn = cross2(ax - px, ay - py, px - qx, py - qy);
		un = cross2(bx - ax, by - ay, ax - px, ay - py);
		return in_unit(tn, den) && in_unit(un, den);
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic seg_t mk_seg(int ax, int ay, int bx, int by);
		seg_t s;
		s.ax = coord_t'(ax);
		s.ay = coord_t'(ay);
		s.bx = coord_t'(bx);
		s.by = coord_t'(by);
		return s;
	endfunction

	// keep a derived coordinate only if it stays on the grid
	function automatic coord_t fit(longint v, coord_t alt);
		return (v >= C_MIN && v <= C_MAX) ? coord_t'(v) : alt;
	endfunction

	// random query shaped around the obstacle so that touches, near misses,
	// collinear overlaps and point queries all turn up often
	function automatic seg_t make_query(seg_t o);
		longint ax, ay, dx, dy, g, r, tmp, n, s, t, ox, oy;
		int pick;
		seg_t q;
		ax = o.ax;
		ay = o.ay;
		dx = longint'(o.bx) - ax;
		dy = longint'(o.by) - ay;
		// smallest grid step along the obstacle
		g = (dx < 0) ? -dx : dx;
		r = (dy < 0) ? -dy : dy;
		while (r != 0) begin
			tmp = g % r;
			g = r;
			r = tmp;
		end
		if (g == 0) begin
			// obstacle is a single point: pick some line through it
			dx = $urandom_range(5, 1);
			dy = longint'($urandom_range(10)) - 5;
			n = 8;
		end else begin
			dx = dx / g;
			dy = dy / g;
			n = g;
		end
		q.ax = coord_t'($urandom);
		q.ay = coord_t'($urandom);
		q.bx = coord_t'($urandom);
		q.by = coord_t'($urandom);
		pick = $urandom_range(99);
		if (pick < 25) begin
			// fully random word, every bit toggles
		end else if (pick < 50) begin
			// endpoints scattered close to the obstacle endpoints
			q.ax = fit(longint'($urandom_range(1) ? o.ax : o.bx) + $urandom_range(64) - 32, q.ax);
			q.ay = fit(longint'($urandom_range(1) ? o.ay : o.by) + $urandom_range(64) - 32, q.ay);
			q.bx = fit(longint'($urandom_range(1) ? o.ax : o.bx) + $urandom_range(64) - 32, q.bx);
			q.by = fit(longint'($urandom_range(1) ? o.ay : o.by) + $urandom_range(64) - 32, q.by);
		end else if (pick < 80) begin
			// along the obstacle line, or shifted one step off it
			ox = 0;
			oy = 0;
			if (pick >= 65) begin
				t = $urandom_range(1) ? 1 : -1;
				ox = -dy * t;
				oy = dx * t;
			end
			s = longint'($urandom_range(2 * n + 4)) - n / 2 - 2;
			t = longint'($urandom_range(2 * n + 4)) - n / 2 - 2;
			q.ax = fit(ax + s * dx + ox, o.ax);
			q.ay = fit(ay + s * dy + oy, o.ay);
			q.bx = fit(ax + t * dx + ox, o.bx);
			q.by = fit(ay + t * dy + oy, o.by);
		end else if (pick < 90) begin
			// degenerate query: one point, on the obstacle or just beside it
			s = $urandom_range(n);
			q.ax = fit(ax + s * dx, o.ax);
			q.ay = fit(ay + s * dy + ($urandom_range(3) == 0 ? 1 : 0), o.ay);
			q.bx = q.ax;
			q.by = q.ay;
		end else begin
			// query starts exactly on an obstacle endpoint
			q.ax = $urandom_range(1) ? o.ax : o.bx;
			q.ay = (q.ax == o.ax) ? o.ay : o.by;
		end
		return q;
	endfunction

	// ---------------------------------------------------------------- config port

	task automatic put_reg(cfg_reg_t idx, coord_t val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_obstacle(seg_t o);
		put_reg(CFG_SEG_AX, o.ax);
		put_reg(CFG_SEG_AY, o.ay);
		put_reg(CFG_SEG_BX, o.bx);
		put_reg(CFG_SEG_BY, o.by);
		n_settings++;
	endtask

	// wait until every queued word went in and every hit came back, then let
	// the four-stage pipe settle before the next register write
	task automatic drain();
		@(posedge clk);
		while (query_q.size() != 0 || in_valid || hit_due_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- driver

	// offers the next query word at the falling edge; a word stays put until taken
	always @(negedge clk) begin : drive_query
		seg_t nxt;
		if (!in_valid || in_acc) begin
			if (query_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				nxt = query_q.pop_front();
				in_valid <= 1'b1;
				query_ax <= nxt.ax;
				query_ay <= nxt.ay;
				query_bx <= nxt.bx;
				query_by <= nxt.by;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long hold-off counter, armed once by the stimulus
	always @(negedge clk) begin
		if (hold_arm)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall);
	end

	// ---------------------------------------------------------------- monitors

	// config writes update the obstacle copy; accepted words get their hit predicted
	always @(posedge clk) begin : watch_input
		bit flat;
		bit h;
		in_acc <= in_valid && in_ready;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SEG_AX: obstacle.ax = cfg_data;
				CFG_SEG_AY: obstacle.ay = cfg_data;
				CFG_SEG_BX: obstacle.bx = cfg_data;
				CFG_SEG_BY: obstacle.by = cfg_data;
				default: ;
			endcase
		end
		if (in_valid && in_ready) begin
			h = touches(obstacle, {query_ax, query_ay, query_bx, query_by}, flat);
			hit_due_q.push_back(h);
			n_queries++;
			n_hits += h;
			n_flat += flat;
		end
		// length of the longest run of a word waiting at the input
		if (in_valid && !in_ready) begin
			stall_run++;
			if (stall_run > stall_max)
				stall_max = stall_run;
		end else begin
			stall_run = 0;
		end
	end

	// every result word is checked against the oldest prediction
	always @(posedge clk) begin : check_output
		bit due;
		if (out_valid && out_ready) begin
			if (hit_due_q.size() == 0) begin
				$error("hit: result word %0b with no query outstanding", hit);
				errors++;
			end else begin
				due = hit_due_q.pop_front();
				if (hit !== due) begin
					$error("hit: expected %0b, got %0b", due, hit);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("segment_segment_intersection_top_tb NOT OK");
			$finish;
		end
	end

	// ---------------------------------------------------------------- test sequence

	initial begin : stimulus
		seg_t obs_tab[N_PHASES];
		int send_tab[4];
		int recv_tab[4];
		send_tab = '{0, 83, 0, 20};
		recv_tab = '{0, 0, 83, 20};

		// extremes, diagonals, a horizontal and a vertical, a point, a short one,
		// and two drawn at random
		obs_tab[0] = mk_seg(-32768, -32768, 32767, 32767);
		obs_tab[1] = mk_seg(32767, -32768, -32768, 32767);
		obs_tab[2] = mk_seg(-1000, 200, 3000, 200);
		obs_tab[3] = mk_seg(500, -32768, 500, 32767);
		obs_tab[4] = mk_seg(-7, 3, 21, -11);
		obs_tab[5] = mk_seg(1234, -4321, 1234, -4321);
		obs_tab[6] = {coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom)};
		obs_tab[7] = {coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom)};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// obstacle straight out of reset: a point at the origin
		@(posedge clk);
		query_q.push_back(mk_seg(0, 0, 0, 0));
		query_q.push_back(mk_seg(-1, -1, 1, 1));
		query_q.push_back(mk_seg(1, 0, 2, 0));
		drain();

		// directed queries against a horizontal obstacle (-10,0)-(10,0)
		write_obstacle(mk_seg(-10, 0, 10, 0));
		@(posedge clk);
		query_q.push_back(mk_seg(0, -5, 0, 5));			// plain crossing
		query_q.push_back(mk_seg(0, 0, 0, 5));			// t-junction on query end
		query_q.push_back(mk_seg(10, 0, 15, 5));		// endpoints meet
		query_q.push_back(mk_seg(11, -5, 11, 5));		// just past the end
		query_q.push_back(mk_seg(10, 1, 11, 0));		// near miss on a diagonal
		query_q.push_back(mk_seg(-10, 1, 10, 1));		// parallel, one row off
		query_q.push_back(mk_seg(5, 0, 20, 0));			// collinear overlap
		query_q.push_back(mk_seg(10, 0, 20, 0));		// collinear, touching end
		query_q.push_back(mk_seg(11, 0, 20, 0));		// collinear, apart
		query_q.push_back(mk_seg(-30, 0, 30, 0));		// collinear, covering
		query_q.push_back(mk_seg(10, 0, -10, 0));		// same segment reversed
		query_q.push_back(mk_seg(3, 0, 3, 0));			// point on the obstacle
		query_q.push_back(mk_seg(3, 1, 3, 1));			// point off the line
		query_q.push_back(mk_seg(12, 0, 12, 0));		// point on the line, outside
		query_q.push_back(mk_seg(-32768, -32768, 32767, 32767));
		query_q.push_back(mk_seg(32767, -32768, -32768, 32767));
		query_q.push_back(mk_seg(-32768, 32767, 32767, 32767));
		query_q.push_back(mk_seg(-32768, -32768, -32768, -32768));
		query_q.push_back(mk_seg(32767, 0, -32768, 0));
		drain();

		// random phases, each with its own obstacle and idle mix
		for (int p = 0; p < N_PHASES; p++) begin
			write_obstacle(obs_tab[p]);
			@(posedge clk);
			send_idle = send_tab[p % 4];
			recv_stall = recv_tab[p % 4];
			for (int i = 0; i < RAND_PER_PHASE; i++)
				query_q.push_back(make_query(obstacle));
			if (p == 4) begin
				// receiver holds off for a long stretch at full input rate
				hold_arm = 1'b1;
				@(posedge clk);
				hold_arm = 1'b0;
			end
			drain();
		end

		repeat (12) @(posedge clk);
		if (hit_due_q.size() != 0) begin
			$error("hit: %0d predicted result words never arrived", hit_due_q.size());
			errors++;
		end

		$display("ran %0d queries (%0d touching, %0d on parallel lines) over %0d obstacles",
			n_queries, n_hits, n_flat, n_settings + 1);
		$display("longest wait of a query word at the input: %0d cycles", stall_max);
		if (errors == 0) begin
			$display("segment_segment_intersection_top_tb OK");
		end else begin
			$display("segment_segment_intersection_top_tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ssi_pkg.sv
rtl/core/segment_segment_intersection_top.sv
tb/sv/segment_segment_intersection_top_tb.sv
